@@ rtl/core/a85_pkg.sv @@
// Shared types and constants for the base-85 stream encoder.
`default_nettype none

package a85_pkg;

    typedef logic [6:0] t_a85_char;

    // Reciprocal of 85 scaled by 2^38; exact quotient for every 32-bit dividend.
    localparam logic [31:0] C_RECIP      = 32'hC0C0_C0C1;
    localparam int          C_RECIP_SHR  = 38;
    localparam t_a85_char   C_BASE       = 7'd85;
    localparam t_a85_char   C_OFFSET     = 7'h21;
    localparam t_a85_char   C_ZERO_CHAR  = 7'h7A;
    localparam t_a85_char   C_TILDE      = 7'h7E;
    localparam t_a85_char   C_GT         = 7'h3E;
    localparam t_a85_char   C_NEWLINE    = 7'h0A;
    localparam logic [2:0]  C_NDIG_FULL  = 3'd5;
    localparam logic [2:0]  C_STEP_LAST  = 3'd4;
    localparam logic [3:0]  C_TRAILER_LEN = 4'd3;
    localparam int          C_MAX_CHARS  = 8;

    // One group handed from the front to the converter.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  ndig;
        logic        zero;
        logic        trailer;
    } t_a85_job;

    // Converted group: base-85 digits, least significant in entry 0.
    typedef struct packed {
        logic [4:0][6:0] dig;
        logic [2:0]      ndig;
        logic            zero;
        logic            trailer;
    } t_a85_grp;

    function automatic t_a85_char f_trailer(input logic [1:0] idx);
        t_a85_char ch;
        unique case (idx)
            2'd0:    ch = C_TILDE;
            2'd1:    ch = C_GT;
            2'd2:    ch = C_NEWLINE;
            default: ch = C_NEWLINE;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ascii85_stream_encoder.sv @@
// Top level of the base-85 stream encoder: front, job queue, converter, emitter.
//
//  Channel | Direction | tdata                   | tlast
//  --------+-----------+-------------------------+--------------------------------
//  s_*     | in        | sample[15:0] (byte 15:8)| end_of_data
//  m_*     | out       | out_char[6:0], pad bit 7| run_last (last char of an item)
//
// A byte is taken every cycle while the job queue has room; a group passes through
// the converter with one reciprocal divide by 85 per digit, and its characters leave
// at one per cycle while m_tready is high. Reset (i_rst_n low at a clock edge) empties
// the queue and drops any partial group. A stalled m side fills the emitter, then the
// converter, then the queue, and only then drops s_tready.
`default_nettype none

module ascii85_stream_encoder import a85_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] out_char, [7] always zero
    output logic             m_tlast
);

    logic     w_push, w_full, w_pop, w_qvalid, w_cvalid, w_take;
    t_a85_job w_job_in, w_job_out;
    t_a85_grp w_grp;

    a85_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_sample (s_tdata),
        .i_last   (s_tlast),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    a85_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_job_out)
    );

    a85_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .o_pop   (w_pop),
        .i_job   (w_job_out),
        .o_valid (w_cvalid),
        .i_take  (w_take),
        .o_grp   (w_grp)
    );

    a85_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cvalid),
        .o_take   (w_take),
        .i_grp    (w_grp),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_tdata  (m_tdata),
        .o_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/a85_front.sv @@
// Input side: gathers bytes into groups and issues conversion jobs.
`default_nettype none

module a85_front import a85_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire logic [15:0] i_sample,
    input  wire logic     i_last,
    input  wire logic     i_full,
    output logic          o_push,
    output t_a85_job      o_job
);

    logic [23:0] r_bytes, n_bytes;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  w_byte;
    logic        w_accept;
    logic        w_group_full;

    assign w_byte       = i_sample[15:8];
    assign o_ready      = !i_full;
    assign w_accept     = i_valid && o_ready;
    assign w_group_full = (r_cnt == 2'd3);
    assign o_push       = w_accept && (w_group_full || i_last);

    always_comb begin
        // Left-justify the bytes; a partial group is padded with zeros.
        unique case (r_cnt)
            2'd0: o_job.word = {w_byte, 24'h0};
            2'd1: o_job.word = {r_bytes[7:0], w_byte, 16'h0};
            2'd2: o_job.word = {r_bytes[15:0], w_byte, 8'h0};
            2'd3: o_job.word = {r_bytes, w_byte};
            default: o_job.word = {r_bytes, w_byte};
        endcase
        o_job.ndig    = w_group_full ? C_NDIG_FULL : (3'(r_cnt) + 3'd2);
        o_job.zero    = w_group_full && (o_job.word == 32'h0);
        o_job.trailer = i_last;
    end

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        if (w_accept) begin
            if (w_group_full || i_last) begin
                n_cnt = 2'd0;
            end else begin
                n_cnt   = r_cnt + 2'd1;
                n_bytes = {r_bytes[15:0], w_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_bytes <= 24'h0;
        end else begin
            r_cnt   <= n_cnt;
            r_bytes <= n_bytes;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/a85_fifo.sv @@
// Short job queue between the front and the converter.
`default_nettype none

module a85_fifo import a85_pkg::*; #(
    parameter int P_DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_a85_job i_data,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_a85_job      o_data
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_a85_job        r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] ptr);
        return (ptr == AW'(P_DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= f_next(r_wr);
            if (i_pop)  r_rd <= f_next(r_rd);
            priority if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue read while empty");
`endif

endmodule

`default_nettype wire

@@ rtl/core/a85_conv.sv @@
// Base-85 converter: one reciprocal divide by 85 per cycle, five digits per job.
`default_nettype none

module a85_conv import a85_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_pop,
    input  wire t_a85_job i_job,
    output logic          o_valid,
    input  wire logic     i_take,
    output t_a85_grp      o_grp
);

    logic        r_busy, r_done;
    logic [2:0]  r_step;
    logic [31:0] r_cur;
    t_a85_char   r_prev;
    t_a85_grp    r_grp;
    logic [63:0] w_prod;
    logic [31:0] n_quot;
    t_a85_char   w_rem;

    assign o_pop   = i_valid && !r_busy && (!r_done || i_take);
    assign o_valid = r_done;
    assign o_grp   = r_grp;

    assign w_prod = {32'h0, r_cur} * {32'h0, C_RECIP};
    assign n_quot = 32'(w_prod[63:C_RECIP_SHR]);
    // Remainder of the previous value from its registered quotient; low bits suffice.
    assign w_rem  = r_prev - 7'(r_cur[6:0] * C_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            priority if (o_pop) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= 3'd0;
            end else if (r_busy) begin
                if (r_step == C_STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end else if (r_done && i_take) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur         <= i_job.word;
            r_grp.ndig    <= i_job.ndig;
            r_grp.zero    <= i_job.zero;
            r_grp.trailer <= i_job.trailer;
        end else if (r_busy) begin
            r_cur  <= n_quot;
            r_prev <= r_cur[6:0];
            for (int k = 0; k < 4; k++) begin
                if (r_step == 3'(k + 1)) r_grp.dig[k] <= w_rem;
            end
            // Top digit is the final quotient itself.
            if (r_step == C_STEP_LAST) r_grp.dig[4] <= r_cur[6:0];
        end
    end

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("converter busy and done at once");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step == C_STEP_LAST)) |=> (r_done && !r_busy))
        else $error("converter missed its last step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/a85_emit.sv @@
// Output side: lays out a group's characters, shifts them out one per cycle when ready.
`default_nettype none

module a85_emit import a85_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_take,
    input  wire t_a85_grp i_grp,
    output logic          o_tvalid,
    input  wire logic     i_tready,
    output logic [7:0]    o_tdata,
    output logic          o_tlast
);

    t_a85_char  r_chars [C_MAX_CHARS];
    t_a85_char  w_chars [C_MAX_CHARS];
    logic [3:0] r_cnt, w_len;
    logic [2:0] w_lead;
    logic [3:0] w_idx [C_MAX_CHARS];
    logic       w_xfer, w_load_ok;

    assign w_xfer    = o_tvalid && i_tready;
    assign w_load_ok = (r_cnt == 4'd0) || ((r_cnt == 4'd1) && i_tready);
    assign o_take    = i_valid && w_load_ok;

    assign o_tvalid = (r_cnt != 4'd0);
    assign o_tdata  = {1'b0, r_chars[0]};
    assign o_tlast  = (r_cnt == 4'd1);

    assign w_lead = i_grp.zero ? 3'd1 : i_grp.ndig;
    assign w_len  = {1'b0, w_lead} + (i_grp.trailer ? C_TRAILER_LEN : 4'd0);

    always_comb begin
        for (int p = 0; p < C_MAX_CHARS; p++) begin
            w_idx[p] = 4'(p) - {1'b0, w_lead};
            priority if (i_grp.zero && (p == 0)) begin
                w_chars[p] = C_ZERO_CHAR;
            end else if (!i_grp.zero && (4'(p) < {1'b0, i_grp.ndig})) begin
                // Most significant digit first.
                w_chars[p] = i_grp.dig[(p < 5) ? (4 - p) : 0] + C_OFFSET;
            end else if (w_idx[p] < C_TRAILER_LEN) begin
                w_chars[p] = f_trailer(w_idx[p][1:0]);
            end else begin
                w_chars[p] = C_NEWLINE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (o_take) begin
            r_cnt <= w_len;
        end else if (w_xfer) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int p = 0; p < C_MAX_CHARS; p++) r_chars[p] <= w_chars[p];
        end else if (w_xfer) begin
            // Advance the line by one character.
            for (int p = 0; p < C_MAX_CHARS - 1; p++) r_chars[p] <= r_chars[p + 1];
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(C_MAX_CHARS))
        else $error("character count out of range");
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xfer && o_tlast && !o_take) |=> !o_tvalid)
        else $error("output still valid after last character of a run");
`endif

endmodule

`default_nettype wire
